// ===== rtl/sha1e_pkg.sv =====
// Shared types, codes and constants of the SHA-1 hash engine.
`timescale 1ns / 1ps
`default_nettype none
package sha1e_pkg;

	// input command codes
	localparam logic [1:0] MODE_PUSH   = 2'd0;
	localparam logic [1:0] MODE_FINISH = 2'd1;
	localparam logic [1:0] MODE_START  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_ERR    = 2'd2;
	localparam logic [1:0] ST_DIGEST = 2'd3;

	// byte source for the block buffer
	localparam logic [1:0] BSEL_DATA  = 2'd0;
	localparam logic [1:0] BSEL_PAD80 = 2'd1;
	localparam logic [1:0] BSEL_ZERO  = 2'd2;
	localparam logic [1:0] BSEL_LEN   = 2'd3;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [7:0]  PAD_BYTE   = 8'h80;
	localparam logic [5:0]  LEN_POS    = 6'd56;
	localparam logic [5:0]  FILL_LAST  = 6'd63;
	localparam logic [6:0]  ROUND_LAST = 7'd79;
	localparam logic [2:0]  WORD_LAST  = 3'd4;
	localparam logic [63:0] MAX_BITS   = 64'hFFFF_FFFF_FFFF_FFF7;

	typedef struct packed {
		logic       init;
		logic       push;
		logic [1:0] byte_sel;
		logic       add_len;
		logic       load;
		logic       round;
		logic       add;
		logic       out_load;
		logic [1:0] out_status;
		logic [2:0] out_index;
		logic       out_last;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic       len_ovf;
		logic       last_round;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/sha1_hash_engine.sv =====
// Top level of the SHA-1 hash engine: controller and datapath.
//
//  channel | handshake            | words carried
//  --------+----------------------+------------------------------------------
//  cmd     | cmd_valid/cmd_ready  | mode, data_byte
//  res     | res_valid/res_ready  | status, digest_word, word_index, last
//
// The 64th byte of a block also starts a compression (hash load, 80 rounds of the
// single round unit, hash update) before the next command is taken.
// A first finish writes padding one byte per cycle up to the block end, runs one or
// two compressions, then issues five digest words, one per cycle unless stalled.
// Reset is asynchronous and loads the initial hash and clears all counters.
// A stalled result holds in the output register; a new word is taken while it
// waits only if it is being read in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module sha1_hash_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [7:0]  data_byte,
	output logic             res_valid,
	input  wire logic        res_ready,
	output logic [1:0]       status,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last
);

	sha1e_pkg::cmd_t cmd;
	sha1e_pkg::sts_t sts;

	sha1e_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.mode      (mode),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sha1e_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.sts         (sts),
		.status      (status),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last        (last)
	);

endmodule
`default_nettype wire

// ===== rtl/sha1e_dp.sv =====
// Datapath: hash words, block word line, length counter, round unit, result register.
`timescale 1ns / 1ps
`default_nettype none
module sha1e_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha1e_pkg::cmd_t   cmd,
	input  wire logic [7:0]        data_byte,
	output sha1e_pkg::sts_t        sts,
	output logic [1:0]             status,
	output logic [31:0]            digest_word,
	output logic [2:0]             word_index,
	output logic                   last
);

	logic [4:0][31:0]  h_q;
	logic [15:0][31:0] w_q;
	logic [23:0]       acc_q;
	logic [5:0]        fill_q;
	logic [63:0]       len_q;
	logic [6:0]        round_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;

	logic [7:0]  byte_in;
	logic [7:0]  len_byte;
	logic [31:0] word_in;
	logic [31:0] f_val, k_val, t_val, sched_x, h_sel;

	assign len_byte = 8'(len_q >> {~fill_q[2:0], 3'b000});

	always_comb begin
		case (cmd.byte_sel)
			sha1e_pkg::BSEL_DATA:  byte_in = data_byte;
			sha1e_pkg::BSEL_PAD80: byte_in = sha1e_pkg::PAD_BYTE;
			sha1e_pkg::BSEL_LEN:   byte_in = len_byte;
			default:               byte_in = 8'h00;
		endcase
	end

	assign word_in = {acc_q, byte_in};

	always_comb begin
		if (round_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = sha1e_pkg::K0;
		end else if (round_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1e_pkg::K1;
		end else if (round_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = sha1e_pkg::K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1e_pkg::K3;
		end
	end

	assign t_val   = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_q[0] + k_val;
	// w_q[0] is W[t]; the taps below give W[t+16]
	assign sched_x = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];

	always_comb begin
		case (cmd.out_index)
			3'd0:    h_sel = h_q[0];
			3'd1:    h_sel = h_q[1];
			3'd2:    h_sel = h_q[2];
			3'd3:    h_sel = h_q[3];
			3'd4:    h_sel = h_q[4];
			default: h_sel = 32'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q     <= sha1e_pkg::H_INIT;
			fill_q  <= '0;
			len_q   <= '0;
			round_q <= '0;
		end else begin
			if (cmd.init) begin
				h_q    <= sha1e_pkg::H_INIT;
				fill_q <= '0;
				len_q  <= '0;
			end
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
				if (cmd.add_len)
					len_q <= len_q + 64'd8;
			end
			if (cmd.load)
				round_q <= '0;
			if (cmd.round)
				round_q <= round_q + 7'd1;
			if (cmd.add) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= word_in[23:0];
			if (fill_q[1:0] == 2'd3)
				w_q <= {word_in, w_q[15:1]};
		end
		if (cmd.round)
			w_q <= {{sched_x[30:0], sched_x[31]}, w_q[15:1]};
		if (cmd.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end
		if (cmd.round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (cmd.out_load) begin
			status      <= cmd.out_status;
			digest_word <= (cmd.out_status == sha1e_pkg::ST_DIGEST) ? h_sel : 32'h0;
			word_index  <= cmd.out_index;
			last        <= cmd.out_last;
		end
	end

	assign sts.fill       = fill_q;
	assign sts.len_ovf    = len_q > sha1e_pkg::MAX_BITS;
	assign sts.last_round = round_q == sha1e_pkg::ROUND_LAST;

endmodule
`default_nettype wire

// ===== rtl/sha1e_ctrl.sv =====
// Controller: command decode, padding sequence, compression steps, digest word issue.
`timescale 1ns / 1ps
`default_nettype none
module sha1e_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output logic                  cmd_ready,
	input  wire logic [1:0]       mode,
	output logic                  res_valid,
	input  wire logic             res_ready,
	input  wire sha1e_pkg::sts_t  sts,
	output sha1e_pkg::cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_LOAD  = 3'd2;
	localparam logic [2:0] S_ROUND = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       finished_q, finished_d;
	logic       corrupted_q, corrupted_d;
	logic       pad_q, pad_d;
	logic       first_q, first_d;
	logic       extra_q, extra_d;
	logic       lendone_q, lendone_d;
	logic [2:0] idx_q, idx_d;
	logic       res_valid_q;
	logic       out_free;
	logic       accept;

	assign out_free  = !res_valid_q || res_ready;
	assign cmd_ready = (state_q == S_IDLE) && out_free;
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd         = '0;
		state_d     = state_q;
		finished_d  = finished_q;
		corrupted_d = corrupted_q;
		pad_d       = pad_q;
		first_d     = first_q;
		extra_d     = extra_q;
		lendone_d   = lendone_q;
		idx_d       = idx_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (mode)
						sha1e_pkg::MODE_PUSH: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							if (finished_q) begin
								cmd.out_status = sha1e_pkg::ST_DONE;
							end else if (sts.len_ovf) begin
								corrupted_d    = 1'b1;
								cmd.out_status = sha1e_pkg::ST_ERR;
							end else begin
								cmd.out_status = sha1e_pkg::ST_OK;
								cmd.push       = 1'b1;
								cmd.byte_sel   = sha1e_pkg::BSEL_DATA;
								cmd.add_len    = 1'b1;
								if (sts.fill == sha1e_pkg::FILL_LAST) begin
									pad_d   = 1'b0;
									state_d = S_LOAD;
								end
							end
						end
						sha1e_pkg::MODE_FINISH: begin
							if (corrupted_q) begin
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_status = sha1e_pkg::ST_ERR;
							end else if (finished_q) begin
								idx_d   = '0;
								state_d = S_EMIT;
							end else begin
								pad_d     = 1'b1;
								first_d   = 1'b1;
								extra_d   = sts.fill >= sha1e_pkg::LEN_POS;
								lendone_d = 1'b0;
								state_d   = S_PAD;
							end
						end
						sha1e_pkg::MODE_START: begin
							cmd.init       = 1'b1;
							cmd.out_load   = 1'b1;
							cmd.out_last   = 1'b1;
							cmd.out_status = sha1e_pkg::ST_OK;
							finished_d     = 1'b0;
							corrupted_d    = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			S_PAD: begin
				cmd.push = 1'b1;
				first_d  = 1'b0;
				if (first_q)
					cmd.byte_sel = sha1e_pkg::BSEL_PAD80;
				else if (!extra_q && sts.fill >= sha1e_pkg::LEN_POS)
					cmd.byte_sel = sha1e_pkg::BSEL_LEN;
				else
					cmd.byte_sel = sha1e_pkg::BSEL_ZERO;
				if (sts.fill == sha1e_pkg::FILL_LAST) begin
					// if the length did not fit, this block gets none; the next one carries the length
					if (extra_q)
						extra_d = 1'b0;
					else
						lendone_d = 1'b1;
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				if (sts.last_round)
					state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				if (!pad_q) begin
					state_d = S_IDLE;
				end else if (lendone_q) begin
					pad_d      = 1'b0;
					finished_d = 1'b1;
					idx_d      = '0;
					state_d    = S_EMIT;
				end else begin
					state_d = S_PAD;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = sha1e_pkg::ST_DIGEST;
					cmd.out_index  = idx_q;
					cmd.out_last   = idx_q == sha1e_pkg::WORD_LAST;
					idx_d          = idx_q + 3'd1;
					if (idx_q == sha1e_pkg::WORD_LAST)
						state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			finished_q  <= 1'b0;
			corrupted_q <= 1'b0;
			pad_q       <= 1'b0;
			first_q     <= 1'b0;
			extra_q     <= 1'b0;
			lendone_q   <= 1'b0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			finished_q  <= finished_d;
			corrupted_q <= corrupted_d;
			pad_q       <= pad_d;
			first_q     <= first_d;
			extra_q     <= extra_d;
			lendone_q   <= lendone_d;
			idx_q       <= idx_d;
			if (cmd.out_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sha1e_check.sv =====
// Port-level checker for the SHA-1 hash engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sha1e_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  status,
	input wire logic [31:0] digest_word,
	input wire logic [2:0]  word_index,
	input wire logic        last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(digest_word) && $stable(status))
		else $error("result word changed while stalled");

	a_plain_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != sha1e_pkg::ST_DIGEST |-> digest_word == 32'h0 &&
		word_index == 3'd0 && last)
		else $error("non-digest result carries data or is not last");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == sha1e_pkg::ST_DIGEST |->
		word_index <= sha1e_pkg::WORD_LAST &&
		(last == (word_index == sha1e_pkg::WORD_LAST)))
		else $error("digest index or last flag wrong");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && status == sha1e_pkg::ST_DIGEST && !last
		##1 res_valid |-> status == sha1e_pkg::ST_DIGEST &&
		word_index == $past(word_index) + 3'd1)
		else $error("digest words out of order");

endmodule

bind sha1_hash_engine sha1e_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res_valid),
	.res_ready   (res_ready),
	.status      (status),
	.digest_word (digest_word),
	.word_index  (word_index),
	.last        (last)
);
`default_nettype wire

// ===== tb/tb_sha1_hash_engine.sv =====
// Self-checking testbench for the SHA-1 hash engine: directed and random messages.
`timescale 1ns / 1ps
module tb_sha1_hash_engine;

	// mode 3 is not a command; the engine must swallow it without a result
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam logic [63:0] BITS_PUSH_MAX = 64'hFFFF_FFFF_FFFF_FFF7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_WORDS = 110;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} sha_result_t;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	logic [1:0]  mode;
	logic [7:0]  data_byte;
	logic        res_valid;
	logic        res_ready;
	logic [1:0]  status;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last;

	// predicted engine state
	logic [31:0] hash_st [5];
	logic [7:0]  blk_buf [64];
	int          blk_fill;
	logic [63:0] msg_bits;
	bit          msg_done;
	bit          msg_bad;

	sha_result_t due_results [$];

	bit no_idle;
	int next_gap;
	int n_words;
	int n_nops;
	int n_results;
	int n_digests;
	int n_errs;
	int n_cycles;

	sha1_hash_engine u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.mode       (mode),
		.data_byte  (data_byte),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.status     (status),
		.digest_word(digest_word),
		.word_index (word_index),
		.last       (last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", n_cycles,
				due_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void sha_clear();
		hash_st[0] = 32'h67452301;
		hash_st[1] = 32'hEFCDAB89;
		hash_st[2] = 32'h98BADCFE;
		hash_st[3] = 32'h10325476;
		hash_st[4] = 32'hC3D2E1F0;
		blk_fill   = 0;
		msg_bits   = '0;
		msg_done   = 1'b0;
		msg_bad    = 1'b0;
	endfunction

	function automatic void sha_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, kc, t;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
		for (i = 16; i < 80; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		a = hash_st[0];
		b = hash_st[1];
		c = hash_st[2];
		d = hash_st[3];
		e = hash_st[4];
		for (i = 0; i < 80; i++) begin
			if (i < 20) begin
				f  = (b & c) | (~b & d);
				kc = 32'h5A827999;
			end else if (i < 40) begin
				f  = b ^ c ^ d;
				kc = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f  = (b & c) | (b & d) | (c & d);
				kc = 32'h8F1BBCDC;
			end else begin
				f  = b ^ c ^ d;
				kc = 32'hCA62C1D6;
			end
			t = {a[26:0], a[31:27]} + f + e + w[i] + kc;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_st[0] += a;
		hash_st[1] += b;
		hash_st[2] += c;
		hash_st[3] += d;
		hash_st[4] += e;
		blk_fill = 0;
	endfunction

	function automatic void sha_pad();
		int i;
		blk_buf[blk_fill] = 8'h80;
		blk_fill++;
		// no room left for the length: close this block with zeros first
		if (blk_fill > 56) begin
			while (blk_fill < 64) begin
				blk_buf[blk_fill] = 8'h00;
				blk_fill++;
			end
			sha_compress();
		end
		while (blk_fill < 56) begin
			blk_buf[blk_fill] = 8'h00;
			blk_fill++;
		end
		for (i = 0; i < 8; i++)
			blk_buf[56+i] = msg_bits[63-8*i -: 8];
		sha_compress();
	endfunction

	function automatic void expect_result(logic [1:0] st, logic [31:0] w, logic [2:0] idx,
		logic lst);
		sha_result_t r;
		r.status = st;
		r.word   = w;
		r.index  = idx;
		r.last   = lst;
		due_results.push_back(r);
	endfunction

	function automatic void sha_predict(logic [1:0] m, logic [7:0] b);
		int k;
		case (m)
			sha1e_pkg::MODE_PUSH: begin
				if (msg_done) begin
					expect_result(sha1e_pkg::ST_DONE, '0, '0, 1'b1);
				end else if (msg_bits > BITS_PUSH_MAX) begin
					msg_bad = 1'b1;
					expect_result(sha1e_pkg::ST_ERR, '0, '0, 1'b1);
				end else begin
					blk_buf[blk_fill] = b;
					blk_fill++;
					msg_bits += 64'd8;
					if (blk_fill == 64)
						sha_compress();
					expect_result(sha1e_pkg::ST_OK, '0, '0, 1'b1);
				end
			end
			sha1e_pkg::MODE_FINISH: begin
				if (msg_bad) begin
					expect_result(sha1e_pkg::ST_ERR, '0, '0, 1'b1);
				end else begin
					if (!msg_done) begin
						sha_pad();
						msg_done = 1'b1;
						n_digests++;
					end
					for (k = 0; k < 5; k++)
						expect_result(sha1e_pkg::ST_DIGEST, hash_st[k], 3'(k), k == 4);
				end
			end
			sha1e_pkg::MODE_START: begin
				sha_clear();
				expect_result(sha1e_pkg::ST_OK, '0, '0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	// result side: random stall before each word
	initial begin
		int stall;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		sha_result_t want;
		if (arst_n && res_valid && res_ready) begin
			n_results++;
			if (due_results.size() == 0) begin
				n_errs++;
				if (n_errs <= 10)
					$display("unexpected word: status %0d word %h index %0d last %0b",
						status, digest_word, word_index, last);
			end else begin
				want = due_results.pop_front();
				if (status !== want.status || digest_word !== want.word ||
					word_index !== want.index || last !== want.last) begin
					n_errs++;
					if (n_errs <= 10)
						$display("mismatch: want %0d %h %0d %0b, got %0d %h %0d %0b",
							want.status, want.word, want.index, want.last,
							status, digest_word, word_index, last);
				end
			end
		end
	end

	// called and returns at a falling edge; the gap before the next word is drawn here
	task automatic send_word(input logic [1:0] m, input logic [7:0] b);
		repeat (next_gap) @(negedge clk);
		cmd_valid <= 1'b1;
		mode      <= m;
		data_byte <= b;
		do @(posedge clk); while (!cmd_ready);
		sha_predict(m, b);
		if (m == MODE_NOP)
			n_nops++;
		else
			n_words++;
		@(negedge clk);
		next_gap = no_idle ? 0 : $urandom_range(0, 15);
		if (next_gap > 0)
			cmd_valid <= 1'b0;
	endtask

	task automatic drop_valid();
		if (next_gap == 0)
			cmd_valid <= 1'b0;
	endtask

	task automatic drain_results();
		drop_valid();
		while (due_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// finish straight after reset hashes the empty message
	task automatic test_empty_message();
		send_word(sha1e_pkg::MODE_FINISH, 8'h00);
		send_word(sha1e_pkg::MODE_FINISH, 8'hFF);
		send_word(sha1e_pkg::MODE_PUSH, 8'h5A);
		send_word(MODE_NOP, 8'h00);
		send_word(sha1e_pkg::MODE_START, 8'hFF);
	endtask

	task automatic test_short_message();
		send_word(sha1e_pkg::MODE_PUSH, 8'h00);
		send_word(sha1e_pkg::MODE_PUSH, 8'hFF);
		send_word(sha1e_pkg::MODE_PUSH, 8'h80);
		send_word(sha1e_pkg::MODE_PUSH, 8'h7F);
		send_word(sha1e_pkg::MODE_PUSH, 8'h01);
		send_word(sha1e_pkg::MODE_FINISH, 8'hAA);
		send_word(sha1e_pkg::MODE_PUSH, 8'hAA);
		send_word(sha1e_pkg::MODE_FINISH, 8'h55);
	endtask

	// length overflow and the corrupted finish need 2^61 bytes, so they are predicted
	// but cannot be reached here
	task automatic test_nop_and_restart();
		send_word(sha1e_pkg::MODE_START, 8'h00);
		send_word(MODE_NOP, 8'hFF);
		send_word(sha1e_pkg::MODE_PUSH, 8'h61);
		send_word(MODE_NOP, 8'h3C);
		send_word(sha1e_pkg::MODE_PUSH, 8'h62);
		send_word(sha1e_pkg::MODE_FINISH, 8'h00);
		drain_results();
		send_word(sha1e_pkg::MODE_START, 8'h00);
		send_word(sha1e_pkg::MODE_FINISH, 8'h00);
	endtask

	task automatic test_random_messages();
		int bound_len [9];
		int len, i, msg, base;
		bound_len = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
		base = n_words;
		msg  = 0;
		while (n_words - base < RANDOM_WORDS) begin
			no_idle = (msg % 6 == 5);
			if ($urandom_range(0, 15) < 4)
				len = bound_len[$urandom_range(0, 8)];
			else
				len = $urandom_range(0, 20);
			// a missing start leaves late bytes hitting a finished message
			if ($urandom_range(0, 7) != 0)
				send_word(sha1e_pkg::MODE_START, 8'($urandom));
			for (i = 0; i < len && n_words - base < RANDOM_WORDS; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_word(MODE_NOP, 8'($urandom));
				send_word(sha1e_pkg::MODE_PUSH, 8'($urandom));
			end
			if ($urandom_range(0, 9) != 0)
				send_word(sha1e_pkg::MODE_FINISH, 8'($urandom));
			if ($urandom_range(0, 3) == 0)
				send_word(sha1e_pkg::MODE_FINISH, 8'($urandom));
			if ($urandom_range(0, 5) == 0)
				send_word(sha1e_pkg::MODE_PUSH, 8'($urandom));
			if ($urandom_range(0, 9) == 0)
				drain_results();
			msg++;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		mode      = sha1e_pkg::MODE_PUSH;
		data_byte = 8'h00;
		no_idle   = 1'b0;
		next_gap  = 0;
		n_words   = 0;
		n_nops    = 0;
		n_results = 0;
		n_digests = 0;
		n_errs    = 0;
		n_cycles  = 0;
		sha_clear();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_message();
		test_short_message();
		test_nop_and_restart();
		test_random_messages();

		drop_valid();
		while (due_results.size() != 0) @(posedge clk);
		// a trailing no-op may still be in flight
		repeat (300) @(posedge clk);

		$display("summary: %0d command words (+%0d no-ops), %0d result words, %0d digests",
			n_words, n_nops, n_results, n_digests);
		$display("summary: padding at block-boundary lengths, repeated finish, late bytes");
		if (n_errs == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sha1e_pkg.sv
rtl/sha1e_dp.sv
rtl/sha1e_ctrl.sv
rtl/sha1_hash_engine.sv
rtl/sha1e_check.sv
tb/tb_sha1_hash_engine.sv
